@@ rtl/core/text_console_cursor_engine_unit_macros.svh @@
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_UNIT_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_UNIT_MACROS_SVH

// Condition must hold in the same cycle as the trigger.
`define TCCE_ASSERT_SAME(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("console engine check failed");

// Condition must hold in the cycle after the trigger.
`define TCCE_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("console engine check failed");

`endif

@@ rtl/core/tcce_pkg.sv @@
package tcce_pkg;

	localparam int COL_W = 7;
	localparam int ROW_W = 5;

	localparam logic [1:0] OP_PUT_CHAR = 2'd0;
	localparam logic [1:0] OP_PUT_AT   = 2'd1;
	localparam logic [1:0] OP_READ     = 2'd2;
	localparam logic [1:0] OP_CLEAR    = 2'd3;

	localparam logic [7:0] CH_TAB     = 8'd9;
	localparam logic [7:0] CH_LF      = 8'd10;
	localparam logic [7:0] CH_CR      = 8'd13;
	localparam logic [7:0] CH_BLANK   = 8'h20;
	localparam logic [7:0] INIT_COLOR = 8'h07;

	localparam int TAB_STEP    = 4;
	localparam int QUEUE_DEPTH = 2;

	// What the back end has to do with one item.
	typedef enum logic [2:0] {
		KIND_PRINT,
		KIND_NEWLINE,
		KIND_RETURN,
		KIND_TAB,
		KIND_PUT,
		KIND_READ,
		KIND_CLEAR,
		KIND_BAD
	} kind_t;

	typedef struct packed {
		kind_t            kind;
		logic [7:0]       ch;
		logic [7:0]       color;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
	} cmd_t;

	typedef struct packed {
		logic [7:0]       read_char;
		logic [7:0]       read_color;
		logic [COL_W-1:0] cursor_column;
		logic [ROW_W-1:0] cursor_row;
		logic             scrolled;
		logic             bad_position;
	} res_t;

endpackage

@@ rtl/core/text_console_cursor_engine_unit.sv @@
// Text console engine: a ROWS x COLUMNS screen of character/attribute cells
// plus a cursor. Items arrive on the s_axis channel (tuser is the opcode:
// put character, put at position, read cell, clear screen) and each item
// produces exactly one item on the m_axis channel with the read data, the
// cursor after the item and the scrolled / bad position flags.
// cfg_wr_en/cfg_wr_data set the attribute byte used for printed characters
// and for the row blanked by a scroll; write it only while the engine is idle.
// A front stage classifies items into a two-entry queue, so input is taken
// while the back end works or while a result waits on a stalled receiver.
// An accepted item passes through the queue, then the back end states EXEC,
// RDWAIT (read cell only) and RESULT, and lands in the result register. The
// back end takes the next item only when idle, once the last result is loaded
// and any blanking is done. After its result, a scroll blanks one row and a
// clear screen blanks every cell.
// After reset the engine blanks the whole screen in a clearing pass before
// the first queued item runs.
// A stalled receiver holds the result register; the queue then fills and
// s_axis_tready drops.
module text_console_cursor_engine_unit #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata: char_code, cell_color, column, row (6), zero fill
	input  logic [31:0] s_axis_tdata,
	// tuser: opcode
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// tdata: read_char, read_color, cursor_column (7), cursor_row (5), zero fill
	output logic [31:0] m_axis_tdata,
	// tuser: scrolled, bad_position
	output logic [1:0]  m_axis_tuser,
	input  logic        cfg_wr_en,
	input  logic [7:0]  cfg_wr_data
);

	tcce_pkg::cmd_t front_cmd;
	tcce_pkg::cmd_t queue_cmd;
	tcce_pkg::res_t res;
	logic           queue_valid;
	logic           back_ready;

	tcce_front #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_front (
		.opcode (s_axis_tuser),
		.data   (s_axis_tdata),
		.cmd    (front_cmd)
	);

	tcce_queue #(
		.DEPTH(tcce_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (s_axis_tvalid),
		.push_ready (s_axis_tready),
		.push_cmd   (front_cmd),
		.pop_valid  (queue_valid),
		.pop_ready  (back_ready),
		.pop_cmd    (queue_cmd)
	);

	tcce_back #(
		.COLUMNS(COLUMNS),
		.ROWS   (ROWS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.cmd_valid   (queue_valid),
		.cmd_ready   (back_ready),
		.cmd         (queue_cmd),
		.res_valid   (m_axis_tvalid),
		.res_ready   (m_axis_tready),
		.res         (res)
	);

	assign m_axis_tdata = {4'b0000, res.cursor_row, res.cursor_column, res.read_color,
		res.read_char};
	assign m_axis_tuser = {res.bad_position, res.scrolled};

endmodule

@@ rtl/core/tcce_ram.sv @@
module tcce_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

@@ rtl/core/tcce_front.sv @@
module tcce_front #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic [1:0]     opcode,
	input  logic [31:0]    data,
	output tcce_pkg::cmd_t cmd
);

	localparam logic [8:0] ColLim = 9'(COLUMNS);
	localparam logic [6:0] RowLim = 7'(ROWS);

	logic [7:0] ch;
	logic [7:0] column;
	logic [5:0] row;
	logic       on_screen;

	assign ch        = data[7:0];
	assign column    = data[23:16];
	assign row       = data[29:24];
	assign on_screen = ({1'b0, column} < ColLim) && ({1'b0, row} < RowLim);

	always_comb begin
		cmd.ch    = ch;
		cmd.color = data[15:8];
		cmd.col   = column[tcce_pkg::COL_W-1:0];
		cmd.row   = row[tcce_pkg::ROW_W-1:0];
		unique case (opcode)
			tcce_pkg::OP_PUT_CHAR: begin
				priority if (ch == tcce_pkg::CH_LF) begin
					cmd.kind = tcce_pkg::KIND_NEWLINE;
				end else if (ch == tcce_pkg::CH_CR) begin
					cmd.kind = tcce_pkg::KIND_RETURN;
				end else if (ch == tcce_pkg::CH_TAB) begin
					cmd.kind = tcce_pkg::KIND_TAB;
				end else begin
					cmd.kind = tcce_pkg::KIND_PRINT;
				end
			end
			tcce_pkg::OP_PUT_AT: cmd.kind = on_screen ? tcce_pkg::KIND_PUT : tcce_pkg::KIND_BAD;
			tcce_pkg::OP_READ:   cmd.kind = on_screen ? tcce_pkg::KIND_READ : tcce_pkg::KIND_BAD;
			tcce_pkg::OP_CLEAR:  cmd.kind = tcce_pkg::KIND_CLEAR;
		endcase
	end

endmodule

@@ rtl/core/tcce_queue.sv @@
module tcce_queue #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  tcce_pkg::cmd_t push_cmd,
	output logic           pop_valid,
	input  logic           pop_ready,
	output tcce_pkg::cmd_t pop_cmd
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] PtrLast = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CountFull = CW'(DEPTH);

	tcce_pkg::cmd_t  entries_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;
	logic            do_push;
	logic            do_pop;

	assign push_ready = count_q != CountFull;
	assign pop_valid  = count_q != '0;
	assign pop_cmd    = entries_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

@@ rtl/core/tcce_back.sv @@
module tcce_back #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_wr_en,
	input  logic [7:0]     cfg_wr_data,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  tcce_pkg::cmd_t cmd,
	output logic           res_valid,
	input  logic           res_ready,
	output tcce_pkg::res_t res
);

	localparam int COL_W = tcce_pkg::COL_W;
	localparam int ROW_W = tcce_pkg::ROW_W;
	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam logic [COL_W:0]   ColLim   = (COL_W + 1)'(COLUMNS);
	localparam logic [ROW_W:0]   RowLim   = (ROW_W + 1)'(ROWS);
	localparam logic [ROW_W-1:0] RowLast  = ROW_W'(ROWS - 1);
	localparam logic [AW-1:0]    CellLast = AW'(CELLS - 1);
	localparam logic [COL_W:0]   TabMask  = ~((COL_W + 1)'(tcce_pkg::TAB_STEP - 1));
	localparam logic [15:0]      InitCell = {tcce_pkg::INIT_COLOR, tcce_pkg::CH_BLANK};

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_EXEC   = 5'b00010,
		ST_RDWAIT = 5'b00100,
		ST_RESULT = 5'b01000,
		ST_SWEEP  = 5'b10000
	} state_t;

	// Screen rows are kept as a ring: logical row r lives in physical row
	// (r + top_q) mod ROWS, so a scroll only moves top_q and blanks one row.
	function automatic logic [AW-1:0] cell_addr(input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col, input logic [ROW_W-1:0] top);
		logic [ROW_W:0] sum;
		logic [ROW_W:0] prow;
		sum  = {1'b0, row} + {1'b0, top};
		prow = (sum >= RowLim) ? sum - RowLim : sum;
		return AW'(32'(prow) * COLUMNS + 32'(col));
	endfunction

	state_t           state_q;
	tcce_pkg::cmd_t   cmd_q;
	logic [7:0]       color_q;
	logic [COL_W-1:0] cur_col_q;
	logic [ROW_W-1:0] cur_row_q;
	logic [ROW_W-1:0] top_q;
	tcce_pkg::res_t   res_q;
	tcce_pkg::res_t   out_q;
	logic             out_valid_q;
	logic             sweep_pend_q;
	logic [AW-1:0]    sweep_addr_q;
	logic [AW-1:0]    sweep_last_q;
	logic [15:0]      sweep_data_q;

	logic [COL_W:0]   col_inc;
	logic [COL_W:0]   tab_col;
	logic             at_bottom;
	logic [ROW_W-1:0] top_inc;
	logic [AW-1:0]    row_base;
	logic [COL_W-1:0] ex_col;
	logic [ROW_W-1:0] ex_row;
	logic [ROW_W-1:0] ex_top;
	logic             ex_newline;
	logic             ex_scroll;
	logic             ex_bad;
	logic             ex_clear;
	logic             is_print;
	logic             mem_we;
	logic [AW-1:0]    mem_wa;
	logic [15:0]      mem_wd;
	logic [AW-1:0]    mem_ra;
	logic [15:0]      mem_rd;
	logic             out_load;

	assign col_inc   = {1'b0, cur_col_q} + (COL_W + 1)'(1);
	assign tab_col   = ({1'b0, cur_col_q} + (COL_W + 1)'(tcce_pkg::TAB_STEP)) & TabMask;
	assign at_bottom = cur_row_q == RowLast;
	assign top_inc   = (top_q == RowLast) ? '0 : top_q + ROW_W'(1);
	assign row_base  = AW'(32'(top_q) * COLUMNS);
	assign is_print  = cmd_q.kind == tcce_pkg::KIND_PRINT;

	always_comb begin
		ex_col     = cur_col_q;
		ex_row     = cur_row_q;
		ex_top     = top_q;
		ex_newline = 1'b0;
		ex_bad     = 1'b0;
		ex_clear   = 1'b0;
		unique case (cmd_q.kind)
			tcce_pkg::KIND_PRINT: begin
				if (col_inc >= ColLim) begin
					ex_newline = 1'b1;
				end else begin
					ex_col = col_inc[COL_W-1:0];
				end
			end
			tcce_pkg::KIND_NEWLINE: ex_newline = 1'b1;
			tcce_pkg::KIND_RETURN:  ex_col = '0;
			tcce_pkg::KIND_TAB: begin
				if (tab_col >= ColLim) begin
					ex_newline = 1'b1;
				end else begin
					ex_col = tab_col[COL_W-1:0];
				end
			end
			tcce_pkg::KIND_BAD: ex_bad = 1'b1;
			tcce_pkg::KIND_CLEAR: begin
				ex_col   = '0;
				ex_row   = '0;
				ex_top   = '0;
				ex_clear = 1'b1;
			end
			tcce_pkg::KIND_PUT, tcce_pkg::KIND_READ: begin
			end
		endcase
		ex_scroll = ex_newline && at_bottom;
		if (ex_newline) begin
			ex_col = '0;
			if (at_bottom) begin
				ex_top = top_inc;
			end else begin
				ex_row = cur_row_q + ROW_W'(1);
			end
		end
	end

	// A printed character lands before any scroll takes effect, so it uses
	// the current ring offset.
	always_comb begin
		mem_we = (state_q == ST_SWEEP) || ((state_q == ST_EXEC) &&
			(is_print || (cmd_q.kind == tcce_pkg::KIND_PUT)));
		if (state_q == ST_SWEEP) begin
			mem_wa = sweep_addr_q;
			mem_wd = sweep_data_q;
		end else if (is_print) begin
			mem_wa = cell_addr(cur_row_q, cur_col_q, top_q);
			mem_wd = {color_q, cmd_q.ch};
		end else begin
			mem_wa = cell_addr(cmd_q.row, cmd_q.col, top_q);
			mem_wd = {cmd_q.color, cmd_q.ch};
		end
		mem_ra = cell_addr(cmd_q.row, cmd_q.col, top_q);
	end

	tcce_ram #(
		.WIDTH(16),
		.DEPTH(CELLS)
	) u_screen (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_wa),
		.wr_data (mem_wd),
		.rd_addr (mem_ra),
		.rd_data (mem_rd)
	);

	assign cmd_ready = state_q == ST_IDLE;
	assign out_load  = (state_q == ST_RESULT) && (!out_valid_q || res_ready);
	assign res_valid = out_valid_q;
	assign res       = out_q;

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_q <= cmd;
		end
		if (state_q == ST_EXEC) begin
			res_q.read_char     <= '0;
			res_q.read_color    <= '0;
			res_q.cursor_column <= ex_col;
			res_q.cursor_row    <= ex_row;
			res_q.scrolled      <= ex_scroll;
			res_q.bad_position  <= ex_bad;
		end
		if (state_q == ST_RDWAIT) begin
			res_q.read_char  <= mem_rd[7:0];
			res_q.read_color <= mem_rd[15:8];
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_SWEEP;
			color_q      <= tcce_pkg::INIT_COLOR;
			cur_col_q    <= '0;
			cur_row_q    <= '0;
			top_q        <= '0;
			out_valid_q  <= 1'b0;
			sweep_pend_q <= 1'b0;
			sweep_addr_q <= '0;
			sweep_last_q <= CellLast;
			sweep_data_q <= InitCell;
		end else begin
			if (cfg_wr_en) begin
				color_q <= cfg_wr_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					cur_col_q <= ex_col;
					cur_row_q <= ex_row;
					top_q     <= ex_top;
					if (ex_clear) begin
						sweep_pend_q <= 1'b1;
						sweep_addr_q <= '0;
						sweep_last_q <= CellLast;
						sweep_data_q <= InitCell;
					end else if (ex_scroll) begin
						// The old top row becomes the new bottom row.
						sweep_pend_q <= 1'b1;
						sweep_addr_q <= row_base;
						sweep_last_q <= row_base + AW'(COLUMNS - 1);
						sweep_data_q <= {color_q, tcce_pkg::CH_BLANK};
					end
					state_q <= (cmd_q.kind == tcce_pkg::KIND_READ) ? ST_RDWAIT : ST_RESULT;
				end
				ST_RDWAIT: state_q <= ST_RESULT;
				ST_RESULT: begin
					if (out_load) begin
						sweep_pend_q <= 1'b0;
						state_q      <= sweep_pend_q ? ST_SWEEP : ST_IDLE;
					end
				end
				ST_SWEEP: begin
					if (sweep_addr_q == sweep_last_q) begin
						state_q <= ST_IDLE;
					end else begin
						sweep_addr_q <= sweep_addr_q + AW'(1);
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/core/tcce_checker.sv @@
`include "text_console_cursor_engine_unit_macros.svh"

module tcce_checker #(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [1:0]  m_axis_tuser
);

	// A stalled result holds its value.
	`TCCE_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

	`TCCE_ASSERT_SAME(a_col_range, clk, arst_n, m_axis_tvalid, m_axis_tdata[22:16] < COLUMNS)

	`TCCE_ASSERT_SAME(a_row_range, clk, arst_n, m_axis_tvalid, m_axis_tdata[27:23] < ROWS)

	// A scroll always leaves the cursor at the start of the bottom row.
	`TCCE_ASSERT_SAME(a_scroll_pos, clk, arst_n, m_axis_tvalid && m_axis_tuser[0], (m_axis_tdata[22:16] == 0) && (m_axis_tdata[27:23] == ROWS - 1))

	// A rejected position never carries cell data or a scroll.
	`TCCE_ASSERT_SAME(a_bad_clean, clk, arst_n, m_axis_tvalid && m_axis_tuser[1], (m_axis_tdata[15:0] == 0) && !m_axis_tuser[0])

endmodule

bind text_console_cursor_engine_unit tcce_checker #(
	.COLUMNS(COLUMNS),
	.ROWS   (ROWS)
) u_checker (.*);

@@ sim/text_console_cursor_engine_unit_tb.sv @@
module text_console_cursor_engine_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int COLUMNS      = 80;
	localparam int ROWS         = 25;
	localparam int CELLS        = COLUMNS * ROWS;
	// A clear screen keeps blanking cells long after its own result.
	localparam int SETTLE_CYCLES = CELLS + 200;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int LONG_HOLD     = 400;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic [1:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        cfg_wr_en = 1'b0;
	logic [7:0]  cfg_wr_data = '0;

	// Shadow of the console: cells, cursor and print color.
	logic [15:0] screen_mem [0:CELLS-1];
	logic [6:0]  cur_col;
	logic [4:0]  cur_row;
	logic [7:0]  print_color;

	tcce_pkg::res_t console_results [$];

	int errors = 0;
	int cycles = 0;
	int items_sent = 0;
	int results_seen = 0;
	int scroll_count = 0;
	int bad_count = 0;
	int read_count = 0;
	int clear_count = 0;
	int color_writes = 0;

	// Sender burst state.
	int burst_left = 0;
	int gap_left = 0;
	bit offering = 1'b0;

	// Receiver stall state.
	bit hold_request = 1'b0;
	int stall_left = 0;
	int rx_mode = 0;
	int mode_left = 0;
	int rx_phase = 0;

	text_console_cursor_engine_unit #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timed out with %0d results still pending.", console_results.size());
			$display("[text_console_cursor_engine_unit] ERROR");
			$finish;
		end
	end

	function automatic void blank_screen();
		for (int i = 0; i < CELLS; i++)
			screen_mem[i] = {tcce_pkg::INIT_COLOR, tcce_pkg::CH_BLANK};
		cur_col = '0;
		cur_row = '0;
	endfunction

	function automatic void scroll_screen();
		for (int i = 0; i + COLUMNS < CELLS; i++)
			screen_mem[i] = screen_mem[i + COLUMNS];
		for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++)
			screen_mem[i] = {print_color, tcce_pkg::CH_BLANK};
	endfunction

	function automatic bit advance_line();
		cur_col = '0;
		if (int'(cur_row) + 1 >= ROWS) begin
			scroll_screen();
			cur_row = 5'(ROWS - 1);
			return 1'b1;
		end
		cur_row = cur_row + 5'd1;
		return 1'b0;
	endfunction

	function automatic bit print_char(input logic [7:0] ch);
		int next_col;
		if (ch == tcce_pkg::CH_LF)
			return advance_line();
		if (ch == tcce_pkg::CH_CR) begin
			cur_col = '0;
			return 1'b0;
		end
		if (ch == tcce_pkg::CH_TAB) begin
			next_col = (int'(cur_col) + tcce_pkg::TAB_STEP) & ~(tcce_pkg::TAB_STEP - 1);
			if (next_col >= COLUMNS)
				return advance_line();
			cur_col = 7'(next_col);
			return 1'b0;
		end
		screen_mem[int'(cur_row) * COLUMNS + int'(cur_col)] = {print_color, ch};
		if (int'(cur_col) + 1 >= COLUMNS)
			return advance_line();
		cur_col = cur_col + 7'd1;
		return 1'b0;
	endfunction

	function automatic tcce_pkg::res_t apply_console_op(input logic [1:0] op,
			input logic [7:0] ch, input logic [7:0] attr, input logic [7:0] col,
			input logic [5:0] row);
		tcce_pkg::res_t r;
		bit on_screen;
		int addr;
		r = '0;
		on_screen = (int'(col) < COLUMNS) && (int'(row) < ROWS);
		addr = int'(row) * COLUMNS + int'(col);
		case (op)
			tcce_pkg::OP_PUT_CHAR: begin
				r.scrolled = print_char(ch);
			end
			tcce_pkg::OP_PUT_AT: begin
				if (on_screen)
					screen_mem[addr] = {attr, ch};
				else
					r.bad_position = 1'b1;
			end
			tcce_pkg::OP_READ: begin
				read_count++;
				if (on_screen) begin
					r.read_char  = screen_mem[addr][7:0];
					r.read_color = screen_mem[addr][15:8];
				end else begin
					r.bad_position = 1'b1;
				end
			end
			default: begin
				clear_count++;
				blank_screen();
			end
		endcase
		if (r.scrolled)
			scroll_count++;
		if (r.bad_position)
			bad_count++;
		r.cursor_column = cur_col;
		r.cursor_row    = cur_row;
		return r;
	endfunction

	// Offers one item, holding it until the engine takes it, in bursts with gaps.
	task automatic send_item(input logic [1:0] op, input logic [7:0] ch, input logic [7:0] attr,
			input logic [7:0] col, input logic [5:0] row);
		if (burst_left == 0) begin
			repeat (gap_left) @(posedge clk);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(80, 200)
				: $urandom_range(1, 24);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {2'b00, row, col, attr, ch};
		s_axis_tuser  <= op;
		offering = 1'b1;
		do
			@(posedge clk);
		while (!s_axis_tready);
		console_results.push_back(apply_console_op(op, ch, attr, col, row));
		items_sent++;
		burst_left--;
		if (burst_left == 0) begin
			gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
			if (gap_left == 0) begin
				burst_left = $urandom_range(1, 24);
			end else begin
				s_axis_tvalid <= 1'b0;
				offering = 1'b0;
			end
		end
	endtask

	task automatic stop_offering();
		if (offering) begin
			s_axis_tvalid <= 1'b0;
			offering = 1'b0;
		end
		burst_left = 0;
		gap_left = 0;
		@(posedge clk);
	endtask

	task automatic wait_engine_idle();
		stop_offering();
		while (console_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_text_color(input logic [7:0] value);
		wait_engine_idle();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		print_color = value;
		color_writes++;
	endtask

	task automatic send_random_item(input int lf_pct, input int clear_per_mille);
		logic [1:0] op;
		logic [7:0] ch, attr, col;
		logic [5:0] row;
		int pick;
		ch   = 8'($urandom_range(0, 255));
		attr = 8'($urandom_range(0, 255));
		col  = 8'($urandom_range(0, COLUMNS - 1));
		row  = 6'($urandom_range(0, ROWS - 1));
		// Out-of-range positions now and then, over the full field widths.
		if ($urandom_range(0, 99) < 15) begin
			col = 8'($urandom_range(0, 255));
			row = 6'($urandom_range(0, 63));
		end
		pick = $urandom_range(0, 999);
		if (pick < clear_per_mille) begin
			op = tcce_pkg::OP_CLEAR;
		end else if (pick < 600) begin
			op = tcce_pkg::OP_PUT_CHAR;
			pick = $urandom_range(0, 99);
			if (pick < lf_pct)
				ch = tcce_pkg::CH_LF;
			else if (pick < lf_pct + 6)
				ch = tcce_pkg::CH_CR;
			else if (pick < lf_pct + 16)
				ch = tcce_pkg::CH_TAB;
		end else if (pick < 780) begin
			op = tcce_pkg::OP_PUT_AT;
		end else begin
			op = tcce_pkg::OP_READ;
		end
		send_item(op, ch, attr, col, row);
	endtask

	task automatic run_random(input int count, input int lf_pct, input int clear_per_mille);
		repeat (count) send_random_item(lf_pct, clear_per_mille);
	endtask

	task automatic test_put_and_read();
		send_item(tcce_pkg::OP_PUT_AT, 8'h00, 8'h00, 8'd0, 6'd0);
		send_item(tcce_pkg::OP_PUT_AT, 8'hFF, 8'hFF, 8'(COLUMNS - 1), 6'(ROWS - 1));
		send_item(tcce_pkg::OP_READ, 8'h00, 8'h00, 8'd0, 6'd0);
		send_item(tcce_pkg::OP_READ, 8'hFF, 8'hFF, 8'(COLUMNS - 1), 6'(ROWS - 1));
		send_item(tcce_pkg::OP_READ, 8'h55, 8'hAA, 8'd40, 6'd12);
		stop_offering();
	endtask

	task automatic test_bad_positions();
		send_item(tcce_pkg::OP_PUT_AT, 8'h41, 8'h1E, 8'(COLUMNS), 6'd0);
		send_item(tcce_pkg::OP_PUT_AT, 8'h42, 8'h2F, 8'hFF, 6'h3F);
		send_item(tcce_pkg::OP_PUT_AT, 8'h43, 8'h3C, 8'd0, 6'(ROWS));
		send_item(tcce_pkg::OP_READ, 8'h00, 8'h00, 8'(COLUMNS), 6'd0);
		send_item(tcce_pkg::OP_READ, 8'h00, 8'h00, 8'd0, 6'(ROWS));
		send_item(tcce_pkg::OP_READ, 8'hFF, 8'hFF, 8'hFF, 6'h3F);
		stop_offering();
	endtask

	task automatic test_cursor_control();
		send_item(tcce_pkg::OP_PUT_CHAR, 8'h41, 8'h00, 8'd0, 6'd0);
		send_item(tcce_pkg::OP_PUT_CHAR, tcce_pkg::CH_TAB, 8'h00, 8'd0, 6'd0);
		send_item(tcce_pkg::OP_PUT_CHAR, 8'h00, 8'h00, 8'd0, 6'd0);
		send_item(tcce_pkg::OP_PUT_CHAR, tcce_pkg::CH_TAB, 8'h00, 8'd0, 6'd0);
		send_item(tcce_pkg::OP_PUT_CHAR, tcce_pkg::CH_CR, 8'h00, 8'd0, 6'd0);
		send_item(tcce_pkg::OP_PUT_CHAR, tcce_pkg::CH_LF, 8'h00, 8'd0, 6'd0);
		send_item(tcce_pkg::OP_PUT_CHAR, 8'hFF, 8'h00, 8'd0, 6'd0);
		send_item(tcce_pkg::OP_READ, 8'h00, 8'h00, 8'd4, 6'd0);
		send_item(tcce_pkg::OP_READ, 8'h00, 8'h00, 8'd0, 6'd1);
		send_item(tcce_pkg::OP_CLEAR, 8'h00, 8'h00, 8'd0, 6'd0);
		send_item(tcce_pkg::OP_READ, 8'h00, 8'h00, 8'd0, 6'd1);
		stop_offering();
	endtask

	// Walks the cursor down to the bottom row and scrolls, with random text in between.
	task automatic test_scroll();
		for (int i = 0; i < ROWS + 3; i++) begin
			send_item(tcce_pkg::OP_PUT_CHAR, 8'($urandom_range(32, 126)), 8'h00, 8'd0, 6'd0);
			send_item(tcce_pkg::OP_PUT_CHAR, tcce_pkg::CH_LF, 8'h00, 8'd0, 6'd0);
		end
		// Tab at the end of a row wraps and scrolls as well.
		repeat (COLUMNS / tcce_pkg::TAB_STEP)
			send_item(tcce_pkg::OP_PUT_CHAR, tcce_pkg::CH_TAB, 8'h00, 8'd0, 6'd0);
		for (int i = 0; i < 4; i++)
			send_item(tcce_pkg::OP_READ, 8'h00, 8'h00, 8'($urandom_range(0, COLUMNS - 1)),
				6'(ROWS - 1 - i));
		stop_offering();
	endtask

	task automatic test_backpressure();
		hold_request = 1'b1;
		run_random(60, 15, 0);
		stop_offering();
	endtask

	task automatic test_random_colors();
		set_text_color(8'h00);
		run_random(400, 30, 3);
		set_text_color(8'hFF);
		run_random(400, 10, 3);
		set_text_color(8'($urandom_range(1, 254)));
		run_random(400, 20, 2);
		set_text_color(tcce_pkg::INIT_COLOR);
		run_random(400, 15, 3);
	endtask

	// Receiver: stall modes that change at random intervals, plus one long hold.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (hold_request) begin
				stall_left = LONG_HOLD;
				hold_request = 1'b0;
			end
			if (mode_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(50, 400);
			end else begin
				mode_left--;
			end
			rx_phase++;
			if (stall_left != 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				case (rx_mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= 1'($urandom_range(0, 1));
					2: m_axis_tready <= ($urandom_range(0, 3) == 0);
					default: m_axis_tready <= (rx_phase % 7) > 2;
				endcase
			end
		end
	end

	task automatic check_field(input string name, input int expected, input int actual);
		if (expected != actual) begin
			$error("%s mismatch: expected %0d, got %0d", name, expected, actual);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		tcce_pkg::res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			results_seen++;
			if (console_results.size() == 0) begin
				$error("Result arrived with nothing pending");
				errors++;
			end else begin
				want = console_results.pop_front();
				check_field("read_char", want.read_char, m_axis_tdata[7:0]);
				check_field("read_color", want.read_color, m_axis_tdata[15:8]);
				check_field("cursor_column", want.cursor_column, m_axis_tdata[22:16]);
				check_field("cursor_row", want.cursor_row, m_axis_tdata[27:23]);
				check_field("scrolled", want.scrolled, m_axis_tuser[0]);
				check_field("bad_position", want.bad_position, m_axis_tuser[1]);
			end
		end
	end

	initial begin
		print_color = tcce_pkg::INIT_COLOR;
		blank_screen();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_put_and_read();
		test_bad_positions();
		test_cursor_control();
		test_scroll();
		run_random(300, 15, 2);
		test_backpressure();
		test_random_colors();

		wait_engine_idle();
		$display("Sent %0d items, checked %0d results over %0d cycles.",
			items_sent, results_seen, cycles);
		$display("Seen %0d scrolls, %0d bad positions, %0d reads, %0d clears, %0d color writes.",
			scroll_count, bad_count, read_count, clear_count, color_writes);
		if (errors == 0)
			$display("[text_console_cursor_engine_unit] OK");
		else
			$display("[text_console_cursor_engine_unit] ERROR");
		$finish;
	end

endmodule
